// File: sv/lag_pkg.sv
// lag_pkg: shared constants, types and helpers for the life automaton unit
// no dependencies; compile first
`default_nettype none

package lag_pkg;

  // board geometry defaults and transaction field widths
  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;
  localparam int ROW_BITS     = 64;

  // configuration register widths, indexes and reset values
  localparam int ROW_COUNT_W   = 7;
  localparam int COL_COUNT_W   = 7;
  localparam int GEN_TOTAL_W   = 16;
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_INDEX_W   = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COL_COUNT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_GEN_TOTAL = 2'd2;

  localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RST = 7'd64;
  localparam logic [COL_COUNT_W-1:0] COL_COUNT_RST = 7'd64;
  localparam logic [GEN_TOTAL_W-1:0] GEN_TOTAL_RST = 16'd1;

  // cell operations, broadcast to the whole chain
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_HOLD  = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD  = 3'd1;
  localparam logic [OP_W-1:0] OP_PREP  = 3'd2;
  localparam logic [OP_W-1:0] OP_STEP  = 3'd3;
  localparam logic [OP_W-1:0] OP_SHIFT = 3'd4;

  // per-cell control bundle
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            load_sel;
    logic            active;
  } cell_ctl_t;

  // number of live neighbors among eight
  function automatic logic [3:0] count8(input logic [7:0] nb);
    logic [3:0] sum;
    sum = 4'd0;
    for (int k = 0; k < 8; k++) begin
      sum = sum + 4'(nb[k]);
    end
    return sum;
  endfunction

endpackage

`default_nettype wire

// File: sv/lag_if.sv
// lag_in_if / lag_out_if: valid-ready channels for board rows in and out
// depends on lag_pkg for the row width
`default_nettype none

interface lag_in_if;
  logic                         valid;
  logic                         ready;
  logic [lag_pkg::ROW_BITS-1:0] row_cells;
  logic                         final_row;

  modport source(output valid, output row_cells, output final_row, input ready);
  modport sink(input valid, input row_cells, input final_row, output ready);
endinterface

interface lag_out_if;
  logic                         valid;
  logic                         ready;
  logic [lag_pkg::ROW_BITS-1:0] result_cells;
  logic                         last_result;

  modport source(output valid, output result_cells, output last_result, input ready);
  modport sink(input valid, input result_cells, input last_result, output ready);
endinterface

`default_nettype wire

// File: sv/lag_cell.sv
// lag_cell: one board row of the cell chain, with its own B3/S23 update
// depends on lag_pkg for the control bundle, op codes and neighbor count
`default_nettype none

module lag_cell #(
  parameter int MAX_COLS = lag_pkg::MAX_COLS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire lag_pkg::cell_ctl_t  ctl,
  input  wire logic [MAX_COLS-1:0] mask,
  input  wire logic [MAX_COLS-1:0] load_row,
  input  wire logic [MAX_COLS-1:0] up_row,
  input  wire logic [MAX_COLS-1:0] dn_row,
  output logic      [MAX_COLS-1:0] row
);

  logic [MAX_COLS-1:0] row_r;
  logic [MAX_COLS-1:0] row_nxt;
  logic [MAX_COLS-1:0] life_row;
  logic [MAX_COLS+1:0] up_p;
  logic [MAX_COLS+1:0] mid_p;
  logic [MAX_COLS+1:0] dn_p;

  // pad with dead columns on both edges
  assign up_p  = {1'b0, up_row, 1'b0};
  assign mid_p = {1'b0, row_r, 1'b0};
  assign dn_p  = {1'b0, dn_row, 1'b0};

  // next generation of this row, column by column
  always_comb begin
    logic [3:0] cnt;
    for (int j = 0; j < MAX_COLS; j++) begin
      cnt = lag_pkg::count8({up_p[j], up_p[j+1], up_p[j+2], mid_p[j], mid_p[j+2],
                             dn_p[j], dn_p[j+1], dn_p[j+2]});
      life_row[j] = ((cnt == 4'd3) || ((cnt == 4'd2) && row_r[j])) && mask[j];
    end
  end

  // row update per broadcast operation
  always_comb begin
    case (ctl.op)
      lag_pkg::OP_LOAD:  row_nxt = ctl.load_sel ? load_row : row_r;
      lag_pkg::OP_PREP:  row_nxt = ctl.active ? (row_r & mask) : '0;
      lag_pkg::OP_STEP:  row_nxt = ctl.active ? life_row : '0;
      lag_pkg::OP_SHIFT: row_nxt = dn_row;
      default:           row_nxt = row_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else begin
      row_r <= row_nxt;
    end
  end

  assign row = row_r;

endmodule

`default_nettype wire

// File: sv/life_automaton_generations_unit.sv
// life_automaton_generations_unit: Life B3/S23 board engine, top level
// depends on lag_pkg, lag_in_if / lag_out_if and lag_cell
`default_nettype none

// Loads a board one row per input transaction, one row per cycle; the row flagged
// final_row starts the run. The board sits in a chain of MAX_ROWS cells, one row
// each, that all update together in the same cycle. After the final row the unit
// trims the board to row_count by col_count, then runs generation_total
// generations, then emits the rows in use, one per cycle while out ready is high,
// by shifting the chain toward row 0; the last row carries last_result. The rows
// in use are row_count saturated to 1..MAX_ROWS. Input is accepted again as soon
// as the last row sits in the output register. Sizes outside 1..MAX_ROWS /
// 1..MAX_COLS saturate. Rows past MAX_ROWS are dropped, missing rows are dead,
// and edges do not wrap.

module life_automaton_generations_unit #(
  parameter int MAX_ROWS = lag_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = lag_pkg::MAX_COLS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  lag_in_if.sink                               in_if,
  lag_out_if.source                            out_if,
  input  wire logic                            cfg_wr_en,
  input  wire logic [lag_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [lag_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CNT_W = $clog2(MAX_ROWS + 1);
  localparam int CMP_W = (CNT_W > lag_pkg::ROW_COUNT_W) ? CNT_W : lag_pkg::ROW_COUNT_W;

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_GEN  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  // configuration registers
  logic [lag_pkg::ROW_COUNT_W-1:0] row_count_r;
  logic [lag_pkg::COL_COUNT_W-1:0] col_count_r;
  logic [lag_pkg::GEN_TOTAL_W-1:0] gen_total_r;

  // control state
  logic [1:0]                      state_r, state_nxt;
  logic [CNT_W-1:0]                load_idx_r, load_idx_nxt;
  logic [CNT_W-1:0]                emit_idx_r, emit_idx_nxt;
  logic [lag_pkg::GEN_TOTAL_W-1:0] gen_cnt_r, gen_cnt_nxt;

  // output register
  logic                         out_valid_r, out_valid_nxt;
  logic [lag_pkg::ROW_BITS-1:0] out_cells_r;
  logic                         out_last_r;

  logic                    in_accept;
  logic                    out_load;
  logic                    emit_last;
  logic [CMP_W-1:0]        rc_ext;
  logic [CNT_W-1:0]        rows_eff;
  logic [CNT_W-1:0]        rows_last;
  logic [lag_pkg::COL_COUNT_W-1:0] cols_eff;
  logic [MAX_COLS-1:0]     col_mask;
  logic [lag_pkg::OP_W-1:0] cell_op;
  logic [MAX_COLS-1:0]     rows_w [MAX_ROWS];

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= lag_pkg::ROW_COUNT_RST;
      col_count_r <= lag_pkg::COL_COUNT_RST;
      gen_total_r <= lag_pkg::GEN_TOTAL_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        lag_pkg::CFG_ROW_COUNT: row_count_r <= cfg_data[lag_pkg::ROW_COUNT_W-1:0];
        lag_pkg::CFG_COL_COUNT: col_count_r <= cfg_data[lag_pkg::COL_COUNT_W-1:0];
        lag_pkg::CFG_GEN_TOTAL: gen_total_r <= cfg_data[lag_pkg::GEN_TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  // saturated board size and column mask
  assign rc_ext = CMP_W'(row_count_r);
  always_comb begin
    if (row_count_r == '0) begin
      rows_eff = CNT_W'(1);
    end else if (rc_ext > CMP_W'(MAX_ROWS)) begin
      rows_eff = CNT_W'(MAX_ROWS);
    end else begin
      rows_eff = CNT_W'(rc_ext);
    end
    if (col_count_r == '0) begin
      cols_eff = lag_pkg::COL_COUNT_W'(1);
    end else if (col_count_r > lag_pkg::COL_COUNT_W'(MAX_COLS)) begin
      cols_eff = lag_pkg::COL_COUNT_W'(MAX_COLS);
    end else begin
      cols_eff = col_count_r;
    end
    for (int j = 0; j < MAX_COLS; j++) begin
      col_mask[j] = lag_pkg::COL_COUNT_W'(j) < cols_eff;
    end
  end
  assign rows_last = rows_eff - CNT_W'(1);

  // handshakes
  assign in_if.ready = (state_r == ST_LOAD);
  assign in_accept   = in_if.valid && in_if.ready;
  assign out_load    = (state_r == ST_EMIT) && (!out_valid_r || out_if.ready);
  assign emit_last   = (emit_idx_r == rows_last);

  // sequencer: load, trim, generations, emit
  always_comb begin
    state_nxt     = state_r;
    load_idx_nxt  = load_idx_r;
    emit_idx_nxt  = emit_idx_r;
    gen_cnt_nxt   = gen_cnt_r;
    cell_op       = lag_pkg::OP_HOLD;
    case (state_r)
      ST_LOAD: begin
        if (in_accept) begin
          cell_op = lag_pkg::OP_LOAD;
          if (load_idx_r != CNT_W'(MAX_ROWS)) begin
            load_idx_nxt = load_idx_r + CNT_W'(1);
          end
          if (in_if.final_row) begin
            state_nxt = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        cell_op      = lag_pkg::OP_PREP;
        load_idx_nxt = '0;
        emit_idx_nxt = '0;
        gen_cnt_nxt  = gen_total_r;
        state_nxt    = (gen_total_r == '0) ? ST_EMIT : ST_GEN;
      end
      ST_GEN: begin
        cell_op     = lag_pkg::OP_STEP;
        gen_cnt_nxt = gen_cnt_r - lag_pkg::GEN_TOTAL_W'(1);
        if (gen_cnt_r == lag_pkg::GEN_TOTAL_W'(1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          cell_op      = lag_pkg::OP_SHIFT;
          emit_idx_nxt = emit_idx_r + CNT_W'(1);
          if (emit_last) begin
            state_nxt = ST_LOAD;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      load_idx_r <= '0;
      emit_idx_r <= '0;
      gen_cnt_r  <= '0;
    end else begin
      state_r    <= state_nxt;
      load_idx_r <= load_idx_nxt;
      emit_idx_r <= emit_idx_nxt;
      gen_cnt_r  <= gen_cnt_nxt;
    end
  end

  // chain of row cells
  for (genvar i = 0; i < MAX_ROWS; i++) begin : g_cell
    lag_pkg::cell_ctl_t  ctl;
    logic [MAX_COLS-1:0] up_row;
    logic [MAX_COLS-1:0] dn_row;

    assign ctl.op       = cell_op;
    assign ctl.load_sel = (load_idx_r == CNT_W'(i));
    assign ctl.active   = CNT_W'(i) < rows_eff;

    if (i == 0) begin : g_top
      assign up_row = '0;
    end else begin : g_mid
      assign up_row = rows_w[i-1];
    end
    if (i == MAX_ROWS - 1) begin : g_bot
      assign dn_row = '0;
    end else begin : g_up
      assign dn_row = rows_w[i+1];
    end

    lag_cell #(
      .MAX_COLS(MAX_COLS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .mask     (col_mask),
      .load_row (in_if.row_cells[MAX_COLS-1:0]),
      .up_row   (up_row),
      .dn_row   (dn_row),
      .row      (rows_w[i])
    );
  end

  // output register, fed from the head of the chain
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_cells_r <= lag_pkg::ROW_BITS'(rows_w[0]);
      out_last_r  <= emit_last;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.result_cells = out_cells_r;
  assign out_if.last_result  = out_last_r;

endmodule

`default_nettype wire

// File: sv/lag_checker.sv
// lag_checker: port-level checks of the life automaton unit, bound to its top
// depends on lag_pkg for the row width and on life_automaton_generations_unit
`default_nettype none

module lag_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         in_final_row,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [lag_pkg::ROW_BITS-1:0] out_result_cells,
  input wire logic                         out_last_result
);

  logic in_fin_xact;

  assign in_fin_xact = in_valid && in_ready && in_final_row;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_cells)
                                && $stable(out_last_result))
    else $error("stalled result changed");

  // reset leaves no result pending
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a final row starts a run, so input closes
  a_busy_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    in_fin_xact |=> !in_ready)
    else $error("input still open after final row");

  // input stays open until a final row arrives
  a_open_until_final: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && !in_fin_xact |=> in_ready)
    else $error("input closed without a final row");

endmodule

bind life_automaton_generations_unit lag_checker u_lag_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_if.valid),
  .in_ready         (in_if.ready),
  .in_final_row     (in_if.final_row),
  .out_valid        (out_if.valid),
  .out_ready        (out_if.ready),
  .out_result_cells (out_if.result_cells),
  .out_last_result  (out_if.last_result)
);

`default_nettype wire
